[src/normalized_multi_pattern_counter_unit_assert.svh]
// assertion macros shared by the checker of the pattern counter
// no dependencies; included by files that hold concurrent assertions
`ifndef NORMALIZED_MULTI_PATTERN_COUNTER_UNIT_ASSERT_SVH
`define NORMALIZED_MULTI_PATTERN_COUNTER_UNIT_ASSERT_SVH

// same-cycle implication, masked while reset is held
`define NMPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nmpc assertion failed");

// next-cycle implication, masked while reset is held
`define NMPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nmpc assertion failed");

// next-cycle implication that also holds across reset
`define NMPC_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("nmpc reset assertion failed");

`endif

[src/nmpc_pkg.sv]
// shared constants and pattern table of the normalised pattern counter
// no dependencies; used by the interfaces, matcher, top level and checker
package nmpc_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned PAT_TABLE_SIZE = 17;
  localparam int unsigned MAX_PAT_LEN   = 24;
  localparam int unsigned PAT_W         = MAX_PAT_LEN * BYTE_W;

  // character codes used by the normaliser
  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_CR      = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_GRAVE   = 8'h60;

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(PAT_TABLE_SIZE);

  // patterns right-aligned: the last character sits in the low byte
  localparam logic [PAT_W-1:0] PAT_TEXT [PAT_TABLE_SIZE] = '{
    PAT_W'("ignore previous"),
    PAT_W'("ignore all previous"),
    PAT_W'("ignore the above"),
    PAT_W'("disregard previous"),
    PAT_W'("forget your instructions"),
    PAT_W'("you are now"),
    PAT_W'("act as"),
    PAT_W'("pretend to be"),
    PAT_W'("roleplay as"),
    PAT_W'("new instructions:"),
    PAT_W'("system prompt:"),
    PAT_W'("override:"),
    PAT_W'("jailbreak"),
    PAT_W'("do anything now"),
    PAT_W'("[system]"),
    PAT_W'({"<|im_", "start|>"}),
    PAT_W'({CHAR_GRAVE, CHAR_GRAVE, CHAR_GRAVE, "system"})
  };

  localparam int unsigned PAT_LEN [PAT_TABLE_SIZE] = '{
    15, 19, 16, 18, 24, 11, 6, 13, 11, 17, 14, 9, 9, 15, 8, 12, 9
  };

endpackage

[src/nmpc_if.sv]
// handshake channels of the pattern counter: byte input and count output
// depends on nmpc_pkg for field widths
interface nmpc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          has_byte;
  logic [nmpc_pkg::BYTE_W-1:0]   text_byte;
  logic                          end_of_text;

  modport source (output valid, output has_byte, output text_byte, output end_of_text,
                  input ready);
  modport sink (input valid, input has_byte, input text_byte, input end_of_text,
                output ready);
endinterface

interface nmpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [nmpc_pkg::COUNT_W-1:0]  match_total;

  modport source (output valid, output match_total, input ready);
  modport sink (input valid, input match_total, output ready);
endinterface

[src/nmpc_match.sv]
// parallel comparators: newest window characters against every pattern
// depends on nmpc_pkg for the pattern table and lengths
module nmpc_match #(
  parameter int unsigned WINDOW_CHARS = 24,
  parameter int unsigned NUM_ACTIVE   = 17
) (
  input  logic [WINDOW_CHARS*nmpc_pkg::BYTE_W-1:0] win,
  output logic [NUM_ACTIVE-1:0]                    hit
);

  // one masked compare per pattern over the newest characters
  for (genvar p = 0; p < NUM_ACTIVE; p++) begin : g_pat
    localparam logic [nmpc_pkg::PAT_W-1:0] MASK =
      ~({nmpc_pkg::PAT_W{1'b1}} << (nmpc_pkg::PAT_LEN[p] * nmpc_pkg::BYTE_W));
    assign hit[p] = ((win[nmpc_pkg::PAT_W-1:0] ^ nmpc_pkg::PAT_TEXT[p]) & MASK) == '0;
  end

endmodule

[src/normalized_multi_pattern_counter_unit.sv]
// Normalised multi-pattern counter.
// in_chan takes one beat per text byte (has_byte, text_byte, end_of_text);
// out_chan gives one beat with match_total for every beat that ends a text.
// Whitespace runs collapse to a single space placed before the next printable
// byte, leading and trailing whitespace vanish, letters are lowercased, and the
// resulting characters shift through a window compared against every pattern.
// A beat is taken in every cycle unless a final beat waits in the input
// register: the window, found flags and space tracking update from the input
// register, so one byte per clock is sustained while no final beat waits.
// The count reaches out_chan through the input register, a result holding
// register, then the popcount into the output register.
// A stalled receiver holds up only beats that end a text: two finished counts
// can wait (holding register and output register) while ordinary bytes keep
// flowing; a third final beat waits in the input register.
// Reset (rst_n low, synchronous) empties the pipeline and clears the window,
// flags and space tracking; the first text then starts from a clean state.
// depends on nmpc_pkg, nmpc_if and nmpc_match
module normalized_multi_pattern_counter_unit #(
  parameter int unsigned WINDOW_CHARS = 24,
  parameter int unsigned NUM_PATTERNS = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  nmpc_in_if.sink           in_chan,
  nmpc_out_if.source        out_chan
);

  localparam int unsigned NUM_ACTIVE = (NUM_PATTERNS < nmpc_pkg::PAT_TABLE_SIZE) ?
                                       NUM_PATTERNS : nmpc_pkg::PAT_TABLE_SIZE;
  localparam int unsigned WIN_BITS   = WINDOW_CHARS * nmpc_pkg::BYTE_W;
  localparam int unsigned BW         = nmpc_pkg::BYTE_W;
  localparam int unsigned CW         = nmpc_pkg::COUNT_W;

  function automatic logic [CW-1:0] count_ones(input logic [NUM_ACTIVE-1:0] v);
    logic [CW-1:0] n;
    n = '0;
    for (int i = 0; i < NUM_ACTIVE; i++) begin
      n = n + CW'(v[i]);
    end
    return n;
  endfunction

  // input register
  logic          a_valid_r;
  logic          a_has_r;
  logic [BW-1:0] a_byte_r;
  logic          a_last_r;

  // text state
  logic [WIN_BITS-1:0]   win_r;
  logic [NUM_ACTIVE-1:0] flags_r;
  logic                  seen_r;
  logic                  pend_r;

  // result holding register and output register
  logic                  r_valid_r;
  logic [NUM_ACTIVE-1:0] r_flags_r;
  logic                  out_valid_r;
  logic [CW-1:0]         out_count_r;

  // elastic chain: only beats that end a text need room downstream
  logic out_free, r_adv, r_free, a_adv, in_ready;

  assign out_free = !out_valid_r || out_chan.ready;
  assign r_adv    = r_valid_r && out_free;
  assign r_free   = !r_valid_r || r_adv;
  assign a_adv    = a_valid_r && (!a_last_r || r_free);
  assign in_ready = !a_valid_r || a_adv;

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.match_total = out_count_r;

  // character classification
  logic          is_ws;
  logic [BW-1:0] low_byte;
  logic          push_sp;
  logic          push_ch;

  always_comb begin
    is_ws    = a_byte_r inside {nmpc_pkg::CHAR_SPACE,
                                [nmpc_pkg::CHAR_TAB:nmpc_pkg::CHAR_CR]};
    low_byte = (a_byte_r inside {[nmpc_pkg::CHAR_UPPER_A:nmpc_pkg::CHAR_UPPER_Z]}) ?
               a_byte_r + nmpc_pkg::CASE_OFFSET : a_byte_r;
    push_ch  = a_has_r && !is_ws;
    push_sp  = push_ch && pend_r;
  end

  // window after the pending space, then after the character
  logic [WIN_BITS-1:0]   win_sp;
  logic [WIN_BITS-1:0]   win_ch;
  logic [NUM_ACTIVE-1:0] hit_sp;
  logic [NUM_ACTIVE-1:0] hit_ch;

  assign win_sp = push_sp ? {win_r[WIN_BITS-BW-1:0], nmpc_pkg::CHAR_SPACE} : win_r;
  assign win_ch = push_ch ? {win_sp[WIN_BITS-BW-1:0], low_byte} : win_sp;

  nmpc_match #(.WINDOW_CHARS(WINDOW_CHARS), .NUM_ACTIVE(NUM_ACTIVE)) u_match_sp (
    .win (win_sp),
    .hit (hit_sp)
  );

  nmpc_match #(.WINDOW_CHARS(WINDOW_CHARS), .NUM_ACTIVE(NUM_ACTIVE)) u_match_ch (
    .win (win_ch),
    .hit (hit_ch)
  );

  // next text state
  logic [NUM_ACTIVE-1:0] flags_upd;
  logic                  seen_upd;
  logic                  pend_upd;

  always_comb begin
    flags_upd = flags_r | (hit_sp & {NUM_ACTIVE{push_sp}}) | (hit_ch & {NUM_ACTIVE{push_ch}});
    seen_upd  = seen_r || push_ch;
    if (push_ch) begin
      pend_upd = 1'b0;
    end else if (a_has_r && is_ws) begin
      pend_upd = pend_r || seen_r;
    end else begin
      pend_upd = pend_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      a_has_r  <= in_chan.has_byte;
      a_byte_r <= in_chan.text_byte;
      a_last_r <= in_chan.end_of_text;
    end
  end

  // text state update, cleared at the end of every text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      flags_r <= '0;
      seen_r  <= 1'b0;
      pend_r  <= 1'b0;
    end else if (a_adv) begin
      if (a_last_r) begin
        win_r   <= '0;
        flags_r <= '0;
        seen_r  <= 1'b0;
        pend_r  <= 1'b0;
      end else begin
        win_r   <= win_ch;
        flags_r <= flags_upd;
        seen_r  <= seen_upd;
        pend_r  <= pend_upd;
      end
    end
  end

  // result holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r <= 1'b0;
    end else if (a_adv && a_last_r) begin
      r_valid_r <= 1'b1;
    end else if (r_adv) begin
      r_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_last_r) begin
      r_flags_r <= flags_upd;
    end
  end

  // output register with popcount
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (r_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (r_adv) begin
      out_count_r <= count_ones(r_flags_r);
    end
  end

endmodule

[src/nmpc_checker.sv]
// port-level checks of the pattern counter, attached by bind
// depends on nmpc_pkg and the assertion macro header
`include "normalized_multi_pattern_counter_unit_assert.svh"

module nmpc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [nmpc_pkg::COUNT_W-1:0] match_total
);

  // no count can exceed the number of patterns in the table
  `NMPC_ASSERT_IMP(a_count_range, clk, rst_n, out_valid, match_total <= nmpc_pkg::COUNT_MAX)

  // a receiver that takes every beat never holds up the byte stream
  `NMPC_ASSERT_IMP(a_no_stall_when_drained, clk, rst_n, out_ready, in_ready)

  // a stalled count stays put
  `NMPC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(match_total))

  // reset leaves no stale count behind
  `NMPC_ASSERT_RST(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind normalized_multi_pattern_counter_unit nmpc_checker u_nmpc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .match_total (out_chan.match_total)
);

[tb/sv/normalized_multi_pattern_counter_unit_checker.sv]
`timescale 1ns / 100ps
// checker of the normalised pattern counter: watches both channels, keeps its own
// model of the window and found flags, and compares every count beat
// depends on nmpc_pkg and nmpc_if
module normalized_multi_pattern_counter_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  nmpc_in_if          in_mon,
  nmpc_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned pending_counts
);

  localparam int unsigned WIN_CHARS = 24;
  localparam int unsigned N_PHRASES = 17;
  localparam int unsigned PHRASE_W  = 24 * 8;
  localparam int unsigned SHOW_MAX  = 10;

  localparam logic [7:0] BLANK_SP = 8'h20;
  localparam logic [7:0] BLANK_HT = 8'h09;
  localparam logic [7:0] BLANK_CR = 8'h0D;

  // phrases right-aligned: last character in the low byte, zero padded above
  localparam logic [PHRASE_W-1:0] PHRASES [N_PHRASES] = '{
    PHRASE_W'("ignore previous"),
    PHRASE_W'("ignore all previous"),
    PHRASE_W'("ignore the above"),
    PHRASE_W'("disregard previous"),
    PHRASE_W'("forget your instructions"),
    PHRASE_W'("you are now"),
    PHRASE_W'("act as"),
    PHRASE_W'("pretend to be"),
    PHRASE_W'("roleplay as"),
    PHRASE_W'("new instructions:"),
    PHRASE_W'("system prompt:"),
    PHRASE_W'("override:"),
    PHRASE_W'("jailbreak"),
    PHRASE_W'("do anything now"),
    PHRASE_W'("[system]"),
    PHRASE_W'({"<|im_", "start|>"}),
    PHRASE_W'({8'h60, 8'h60, 8'h60, "system"})
  };

  logic [7:0]                   char_win [WIN_CHARS];
  logic [N_PHRASES-1:0]         hit_flags;
  bit                           seen_text;
  bit                           space_owed;
  logic [nmpc_pkg::COUNT_W-1:0] count_q [$];
  logic [nmpc_pkg::COUNT_W-1:0] want;
  int unsigned                  errs;

  function automatic int unsigned phrase_len(int unsigned idx);
    int unsigned n;
    n = 0;
    while (n < WIN_CHARS && PHRASES[idx][8*n +: 8] != 8'h00) n++;
    return n;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == BLANK_SP || (c >= BLANK_HT && c <= BLANK_CR);
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    if (c >= "A" && c <= "Z") return c + 8'h20;
    return c;
  endfunction

  task automatic clear_scan();
    for (int j = 0; j < WIN_CHARS; j++) char_win[j] = 8'h00;
    hit_flags  = '0;
    seen_text  = 1'b0;
    space_owed = 1'b0;
  endtask

  // shift one normalised character in, then test every phrase against the tail
  task automatic shift_in(logic [7:0] c);
    int unsigned len;
    bit          hit;
    for (int j = 0; j < WIN_CHARS - 1; j++) char_win[j] = char_win[j+1];
    char_win[WIN_CHARS-1] = c;
    for (int unsigned p = 0; p < N_PHRASES; p++) begin
      len = phrase_len(p);
      hit = (len != 0);
      for (int unsigned k = 0; k < len; k++) begin
        if (char_win[WIN_CHARS-1-k] != PHRASES[p][8*k +: 8]) hit = 1'b0;
      end
      if (hit) hit_flags[p] = 1'b1;
    end
  endtask

  // one accepted input beat: whitespace folding, then the count on end of text
  task automatic scan_beat(logic has_byte, logic [7:0] b, logic eot);
    if (has_byte) begin
      if (is_blank(b)) begin
        if (seen_text) space_owed = 1'b1;
      end else begin
        if (space_owed) begin
          shift_in(BLANK_SP);
          space_owed = 1'b0;
        end
        shift_in(fold_case(b));
        seen_text = 1'b1;
      end
    end
    if (eot) begin
      count_q.push_back(nmpc_pkg::COUNT_W'($countones(hit_flags)));
      clear_scan();
    end
  endtask

  // sample at the edge: results are checked before the same edge's input beat
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      count_q.delete();
      errs = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (count_q.size() == 0) begin
          if (errs < SHOW_MAX)
            $display("%0t: count beat with nothing expected, got %0d", $realtime,
                     out_mon.match_total);
          errs++;
        end else begin
          want = count_q.pop_front();
          if (out_mon.match_total !== want) begin
            if (errs < SHOW_MAX)
              $display("%0t: match_total mismatch, expected %0d, got %0d", $realtime,
                       want, out_mon.match_total);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        scan_beat(in_mon.has_byte, in_mon.text_byte, in_mon.end_of_text);
    end
    fail_count     <= errs;
    pending_counts <= count_q.size();
  end

endmodule

[tb/sv/normalized_multi_pattern_counter_unit_tb.sv]
`timescale 1ns / 100ps
// top of the pattern counter testbench: clock, reset, text stimulus, receiver
// stalls, watchdog and verdict; depends on nmpc_pkg, nmpc_if, the block and
// normalized_multi_pattern_counter_unit_checker
module normalized_multi_pattern_counter_unit_tb;

  localparam int unsigned ITEM_TARGET   = 1850;
  localparam int unsigned DRAIN_EVERY   = 350;
  localparam int unsigned HOLD_AT       = 700;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned HOLD_TEXTS    = 30;
  localparam int unsigned TAIL_CYCLES   = 8;
  localparam int unsigned IDLE_LIMIT    = 2000;

  typedef enum int unsigned {SEG_PATTERN, SEG_NEAR_MISS, SEG_NOISE, SEG_BLANKS, SEG_WORD}
    seg_kind_t;
  typedef enum int unsigned {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic clk;
  logic rst_n;

  nmpc_in_if  in_ch ();
  nmpc_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending_counts;

  normalized_multi_pattern_counter_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  normalized_multi_pattern_counter_unit_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .fail_count     (fail_count),
    .pending_counts (pending_counts)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned hold_req   = 0;
  logic [7:0]  text_q [$];

  // one input beat, with bursts and random gaps; returns at the accepting edge
  task automatic send_beat(logic hb, logic [7:0] b, logic eot);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    in_ch.valid       <= 1'b1;
    in_ch.has_byte    <= hb;
    in_ch.text_byte   <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (hb || eot) items_sent++;
  endtask

  // stop sending until every count has come back, then let the pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_counts != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 6))
      0, 1:    return nmpc_pkg::CHAR_SPACE;
      2:       return nmpc_pkg::CHAR_TAB;
      3:       return 8'h0A;
      4:       return 8'h0B;
      5:       return 8'h0C;
      default: return nmpc_pkg::CHAR_CR;
    endcase
  endfunction

  function automatic logic [7:0] mixed_case(logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - nmpc_pkg::CASE_OFFSET;
    return c;
  endfunction

  task automatic push_blanks();
    repeat ($urandom_range(1, 3)) text_q.push_back(blank_char());
  endtask

  // a phrase with random case and whitespace runs; a near miss breaks off early
  task automatic push_phrase(int unsigned idx, bit near_miss);
    int unsigned len;
    int unsigned stop;
    logic [7:0]  c;
    len  = nmpc_pkg::PAT_LEN[idx];
    stop = near_miss ? $urandom_range(1, len - 1) : len;
    for (int unsigned k = 0; k < stop; k++) begin
      c = nmpc_pkg::PAT_TEXT[idx][8*(len-1-k) +: 8];
      if (c == nmpc_pkg::CHAR_SPACE) push_blanks();
      else text_q.push_back(mixed_case(c));
    end
    if (near_miss) text_q.push_back(nmpc_pkg::PAT_TEXT[idx][8*(len-1-stop) +: 8] ^ 8'h01);
  endtask

  // send the built text with stray empty beats; the end rides on a byte or alone
  task automatic deliver_text();
    bit last_on_byte;
    last_on_byte = (text_q.size() > 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned i = 0; i < text_q.size(); i++) begin
      if ($urandom_range(0, 19) == 0) send_beat(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      send_beat(1'b1, text_q[i], last_on_byte && (i + 1 == text_q.size()));
    end
    if (!last_on_byte) send_beat(1'b0, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_random_text();
    int unsigned n_seg;
    int unsigned roll;
    seg_kind_t   kind;
    n_seg = ($urandom_range(0, 11) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 5);
    text_q.delete();
    if ($urandom_range(0, 3) == 0) push_blanks();
    repeat (n_seg) begin
      roll = $urandom_range(0, 99);
      if (roll < 40)      kind = SEG_PATTERN;
      else if (roll < 55) kind = SEG_NEAR_MISS;
      else if (roll < 75) kind = SEG_NOISE;
      else if (roll < 90) kind = SEG_BLANKS;
      else                kind = SEG_WORD;
      case (kind)
        SEG_PATTERN:   push_phrase($urandom_range(0, nmpc_pkg::PAT_TABLE_SIZE - 1), 1'b0);
        SEG_NEAR_MISS: push_phrase($urandom_range(0, nmpc_pkg::PAT_TABLE_SIZE - 1), 1'b1);
        SEG_NOISE:     repeat ($urandom_range(1, 8))
                         text_q.push_back(8'($urandom_range(0, 255)));
        SEG_BLANKS:    push_blanks();
        SEG_WORD:      repeat ($urandom_range(1, 8))
                         text_q.push_back(mixed_case(8'($urandom_range("a", "z"))));
        default:       push_blanks();
      endcase
      if ($urandom_range(0, 1) == 1) push_blanks();
    end
    deliver_text();
  endtask

  task automatic send_short_text();
    text_q.delete();
    repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(0, 255)));
    deliver_text();
  endtask

  // stimulus and verdict
  initial begin
    int unsigned next_drain;
    bit          hold_done;
    in_ch.valid       = 1'b0;
    in_ch.has_byte    = 1'b0;
    in_ch.text_byte   = '0;
    in_ch.end_of_text = 1'b0;
    rst_n             = 1'b0;
    next_drain        = DRAIN_EVERY;
    hold_done         = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: leading blanks, byte extremes, every blank, case edges, empty beat
    send_beat(1'b1, nmpc_pkg::CHAR_SPACE, 1'b0);
    send_beat(1'b1, nmpc_pkg::CHAR_TAB, 1'b0);
    send_beat(1'b1, "A", 1'b0);
    send_beat(1'b1, 8'h00, 1'b0);
    send_beat(1'b1, 8'hFF, 1'b0);
    send_beat(1'b1, 8'h80, 1'b0);
    send_beat(1'b0, 8'hA5, 1'b0);
    send_beat(1'b1, 8'h0A, 1'b0);
    send_beat(1'b1, 8'h0B, 1'b0);
    send_beat(1'b1, 8'h0C, 1'b0);
    send_beat(1'b1, nmpc_pkg::CHAR_CR, 1'b0);
    send_beat(1'b1, "Z", 1'b0);
    send_beat(1'b1, 8'h08, 1'b0);
    send_beat(1'b1, 8'h0E, 1'b0);
    send_beat(1'b1, "@", 1'b0);
    send_beat(1'b1, "[", 1'b0);
    send_beat(1'b1, "x", 1'b1);
    // empty text
    send_beat(1'b0, 8'h5A, 1'b1);
    // folded run inside a phrase, trailing blank on the final beat
    send_beat(1'b1, "A", 1'b0);
    send_beat(1'b1, "C", 1'b0);
    send_beat(1'b1, "T", 1'b0);
    send_beat(1'b1, nmpc_pkg::CHAR_CR, 1'b0);
    send_beat(1'b1, nmpc_pkg::CHAR_SPACE, 1'b0);
    send_beat(1'b1, "a", 1'b0);
    send_beat(1'b1, "S", 1'b0);
    send_beat(1'b1, nmpc_pkg::CHAR_TAB, 1'b1);
    drain();

    // random texts, with drain pauses and one long receiver hold-off
    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_drain) begin
        drain();
        next_drain += DRAIN_EVERY;
      end
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        drain();
        hold_req <= hold_req + 1;
        repeat (HOLD_TEXTS) send_short_text();
      end
      send_random_text();
    end

    drain();
    if (fail_count == 0 && pending_counts == 0) begin
      $display("normalized_multi_pattern_counter_unit_tb: clean");
    end else begin
      $display("normalized_multi_pattern_counter_unit_tb: errors");
    end
    $finish;
  end

  // receiver: changing stall modes, plus a long hold-off on request
  initial begin
    rx_mode_t    mode;
    int unsigned mode_left;
    int unsigned phase;
    int unsigned hold_left;
    int unsigned hold_seen;
    logic        rdy;
    mode      = RX_OPEN;
    mode_left = 0;
    phase     = 0;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 2))
            0:       mode = RX_OPEN;
            1:       mode = RX_RANDOM;
            default: mode = RX_PERIODIC;
          endcase
          mode_left = $urandom_range(20, 200);
          phase     = 0;
        end
        mode_left--;
        case (mode)
          RX_OPEN:     rdy = 1'b1;
          RX_RANDOM:   rdy = ($urandom_range(0, 1) == 1);
          RX_PERIODIC: rdy = ((phase % 7) < 4);
          default:     rdy = 1'b1;
        endcase
        phase++;
      end
      out_ch.ready <= rdy;
    end
  end

  // watchdog: cycles with no beat on either channel
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("normalized_multi_pattern_counter_unit_tb: errors");
        $finish;
      end
    end
  end

endmodule
